// ----- sv/msc_pkg.sv -----
// Shared types and constants for the motor speed command formatter.
// No dependencies.
`default_nettype none
package msc_pkg;

  localparam int unsigned GAIN_COUNT = 4;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned MAG_W      = 7;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [MAG_W-1:0] SAT_LIMIT = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MOTOR1 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MOTOR2 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MOTOR3 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MOTOR4 = 8'd3;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd256;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_FWD  = 8'h46;
  localparam logic [7:0] CH_REV  = 8'h52;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // Position inside a five-byte motor group; in the tail the first two
  // codes select CR and LF.
  typedef enum logic [2:0] {
    FLD_MOTOR,
    FLD_DIR,
    FLD_HUND,
    FLD_TENS,
    FLD_ONES
  } field_e;

  // One formatted motor value.
  typedef struct packed {
    logic       neg;
    logic       hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } motor_fmt_t;

endpackage
`default_nettype wire

// ----- sv/msc_front.sv -----
// Front end: accepts speed items, applies gains, saturates, splits digits.
// Depends on msc_pkg.
`default_nettype none
module msc_front #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire logic                                             in_valid_i,
  output logic                                                  in_ready_o,
  input  wire logic [msc_pkg::GAIN_COUNT*msc_pkg::SPEED_W-1:0]  speeds_i,
  input  wire logic [msc_pkg::GAIN_COUNT-1:0][msc_pkg::GAIN_W-1:0] gains_i,
  output logic                                                  out_valid_o,
  input  wire logic                                             out_ready_i,
  output msc_pkg::motor_fmt_t [MOTOR_COUNT-1:0]                 out_entry_o
);

  localparam int unsigned PW = msc_pkg::PROD_W;
  localparam int unsigned QW = PW - 8;

  logic                          b_v_q;
  logic signed [PW-1:0]          prod_q [MOTOR_COUNT];
  logic                          c_v_q;
  logic [MOTOR_COUNT-1:0]        neg_q;
  logic [msc_pkg::MAG_W-1:0]     mag_q [MOTOR_COUNT];
  logic                          c_ready;
  logic                          b_ready;

  assign c_ready    = !c_v_q || out_ready_i;
  assign b_ready    = !b_v_q || c_ready;
  assign in_ready_o = b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (b_ready) b_v_q <= in_valid_i;
      if (c_ready) c_v_q <= b_v_q;
    end
  end

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_motor
    logic signed [PW-1:0] prod_d;
    logic signed [PW-1:0] biased;
    logic signed [QW-1:0] quot;
    logic                 neg_d;
    logic [msc_pkg::MAG_W-1:0] mag_d;
    logic [QW-1:0]        mag_abs;
    logic [14:0]          recip;
    logic [3:0]           t_all;
    logic [msc_pkg::MAG_W-1:0] ones;

    if (m < msc_pkg::GAIN_COUNT) begin : g_gain
      always_comb begin
        prod_d = $signed(speeds_i[m*msc_pkg::SPEED_W +: msc_pkg::SPEED_W])
               * $signed(gains_i[m]);
      end
    end else begin : g_zero
      assign prod_d = '0;
    end

    always_ff @(posedge clk_i) begin
      if (b_ready && in_valid_i) prod_q[m] <= prod_d;
    end

    // Divide by 256 rounding toward zero, then clamp to +/-100.
    always_comb begin
      biased  = prod_q[m] + (prod_q[m][PW-1] ? PW'(255) : PW'(0));
      quot    = biased[PW-1:8];
      neg_d   = quot[QW-1];
      mag_abs = neg_d ? QW'(-quot) : QW'(quot);
      if (mag_abs > QW'(msc_pkg::SAT_LIMIT)) mag_d = msc_pkg::SAT_LIMIT;
      else                                   mag_d = mag_abs[msc_pkg::MAG_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (c_ready && b_v_q) begin
        neg_q[m] <= neg_d;
        mag_q[m] <= mag_d;
      end
    end

    // Decimal split: x*205>>11 equals x/10 for x up to 100.
    always_comb begin
      recip = 15'(mag_q[m]) * 15'd205;
      t_all = recip[14:11];
      ones  = mag_q[m] - 7'({t_all, 3'b000} + {t_all, 1'b0});
      out_entry_o[m].neg  = neg_q[m];
      out_entry_o[m].hund = (t_all == 4'd10);
      out_entry_o[m].tens = (t_all == 4'd10) ? 4'd0 : t_all;
      out_entry_o[m].ones = ones[3:0];
    end
  end

  assign out_valid_o = c_v_q;

endmodule
`default_nettype wire

// ----- sv/msc_queue.sv -----
// Two-entry queue of formatted frames between front and back end.
// Depends on msc_pkg.
`default_nettype none
module msc_queue #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  wr_valid_i,
  output logic                                       wr_ready_o,
  input  wire msc_pkg::motor_fmt_t [MOTOR_COUNT-1:0] wr_entry_i,
  output logic                                       rd_valid_o,
  input  wire logic                                  rd_pop_i,
  output msc_pkg::motor_fmt_t [MOTOR_COUNT-1:0]      rd_entry_o
);

  msc_pkg::motor_fmt_t [MOTOR_COUNT-1:0] mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;
  assign rd_entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_entry_i;
  end

endmodule
`default_nettype wire

// ----- sv/msc_back.sv -----
// Back end: serializes one queued frame into ASCII bytes, one per cycle while the output accepts.
// Depends on msc_pkg.
`default_nettype none
module msc_back #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  q_valid_i,
  output logic                                       q_pop_o,
  input  wire msc_pkg::motor_fmt_t [MOTOR_COUNT-1:0] q_entry_i,
  output logic                                       m_valid_o,
  input  wire logic                                  m_ready_i,
  output logic [7:0]                                 m_data_o,
  output logic                                       m_last_o
);

  localparam int unsigned MOT_W  = $clog2(MOTOR_COUNT + 1);
  localparam int unsigned MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic [MOT_W-1:0]    mot_q, mot_d;
  msc_pkg::field_e     fld_q, fld_d;
  logic                vld_q;
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;
  logic                fire;
  logic                in_tail;
  msc_pkg::motor_fmt_t cur;

  assign fire    = q_valid_i && (!vld_q || m_ready_i);
  assign in_tail = (mot_q == MOT_W'(MOTOR_COUNT));
  assign cur     = q_entry_i[mot_q[MIDX_W-1:0]];

  always_comb begin
    byte_d  = msc_pkg::CH_CR;
    last_d  = 1'b0;
    mot_d   = mot_q;
    fld_d   = fld_q;
    q_pop_o = 1'b0;
    if (in_tail) begin
      unique case (fld_q)
        msc_pkg::FLD_MOTOR: begin
          byte_d = msc_pkg::CH_CR;
          fld_d  = msc_pkg::FLD_DIR;
        end
        default: begin
          byte_d  = msc_pkg::CH_LF;
          last_d  = 1'b1;
          fld_d   = msc_pkg::FLD_MOTOR;
          mot_d   = '0;
          q_pop_o = fire;
        end
      endcase
    end else begin
      unique case (fld_q)
        msc_pkg::FLD_MOTOR: begin
          byte_d = msc_pkg::CH_ONE + 8'(mot_q);
          fld_d  = msc_pkg::FLD_DIR;
        end
        msc_pkg::FLD_DIR: begin
          byte_d = cur.neg ? msc_pkg::CH_REV : msc_pkg::CH_FWD;
          fld_d  = msc_pkg::FLD_HUND;
        end
        msc_pkg::FLD_HUND: begin
          byte_d = msc_pkg::CH_ZERO + 8'(cur.hund);
          fld_d  = msc_pkg::FLD_TENS;
        end
        msc_pkg::FLD_TENS: begin
          byte_d = msc_pkg::CH_ZERO + 8'(cur.tens);
          fld_d  = msc_pkg::FLD_ONES;
        end
        default: begin
          byte_d = msc_pkg::CH_ZERO + 8'(cur.ones);
          fld_d  = msc_pkg::FLD_MOTOR;
          mot_d  = mot_q + MOT_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mot_q <= '0;
      fld_q <= msc_pkg::FLD_MOTOR;
      vld_q <= 1'b0;
    end else begin
      if (fire) begin
        mot_q <= mot_d;
        fld_q <= fld_d;
      end
      if (fire)           vld_q <= 1'b1;
      else if (m_ready_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign m_valid_o = vld_q;
  assign m_data_o  = byte_q;
  assign m_last_o  = last_q;

endmodule
`default_nettype wire

// ----- sv/motor_speed_command_formatter.sv -----
// Motor speed command formatter, top level: gain registers, front end,
// frame queue and byte serializer. Depends on msc_pkg, msc_front,
// msc_queue and msc_back.
//
// One input transaction carries four signed 16-bit speeds. Each is scaled
// by its gain register (signed, 8 fraction bits), truncated toward zero,
// clamped to -100..100 and sent as an ASCII frame: per motor the digit
// '1'.., 'F' or 'R', three zero-padded digits; then CR and LF, with tlast
// on the LF. A frame is 5*MOTOR_COUNT+2 bytes (22 by default), one byte
// per cycle while the output accepts; the serializer sets the sustained
// rate of speed items once the queue is full, and frames follow one
// another back to back when the next is queued. The first byte passes
// the product register (loaded on the accepting edge), then the clamp
// stage, queue write and output register. Up to three items wait
// behind the frame being sent: one in the queue and two in the front-end
// stages. Motors past the fourth have no input or gain and always read
// "F000". Gains reset to 1.0 (256); writes to register indexes above 3 are
// dropped. Write config only while the block is idle.
`default_nettype none
module motor_speed_command_formatter #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // speed input, fields from bit 0: speed_motor1..speed_motor4, 16 b each
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  // frame output, fields from bit 0: out_byte (8 b); tlast = last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [msc_pkg::GAIN_COUNT-1:0][msc_pkg::GAIN_W-1:0] gain_q;

  logic                                  f_valid, f_ready;
  msc_pkg::motor_fmt_t [MOTOR_COUNT-1:0] f_entry;
  logic                                  q_valid, q_pop;
  msc_pkg::motor_fmt_t [MOTOR_COUNT-1:0] q_entry;
  logic                                  cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Gain register file; out-of-range indexes fall through the case.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(msc_pkg::GAIN_COUNT); i++) begin
        gain_q[i] <= msc_pkg::GAIN_RESET;
      end
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        msc_pkg::REG_GAIN_MOTOR1: gain_q[0] <= cfg_data_i;
        msc_pkg::REG_GAIN_MOTOR2: gain_q[1] <= cfg_data_i;
        msc_pkg::REG_GAIN_MOTOR3: gain_q[2] <= cfg_data_i;
        msc_pkg::REG_GAIN_MOTOR4: gain_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  msc_front #(.MOTOR_COUNT(MOTOR_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .speeds_i    (s_axis_tdata),
    .gains_i     (gain_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_entry_o (f_entry)
  );

  msc_queue #(.MOTOR_COUNT(MOTOR_COUNT)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_entry_i (f_entry),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_entry_o (q_entry)
  );

  msc_back #(.MOTOR_COUNT(MOTOR_COUNT)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_entry_i (q_entry),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  // The frame closer is always a line feed.
  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == msc_pkg::CH_LF)
    else $error("tlast on a byte other than LF");

  // A frame is only retired when one is queued.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  // A write to the first gain register lands on the next cycle.
  a_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire && cfg_index_i == msc_pkg::REG_GAIN_MOTOR1
      |=> gain_q[0] == $past(cfg_data_i))
    else $error("gain write lost");
`endif

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for motor_speed_command_formatter: gain-scaled speed
// items in, ASCII command frames out, checked byte by byte.
// Depends on msc_pkg and the formatter RTL.
`default_nettype none

typedef struct packed {
  logic [7:0] ch;
  logic       last;
} frame_byte_t;

// Keeps a shadow copy of the gain registers and the queue of frame bytes
// still owed by the block.
class frame_scoreboard;
  logic signed [15:0] gains [msc_pkg::GAIN_COUNT];
  frame_byte_t        owed_bytes [$];
  int                 mismatches;
  int                 bytes_checked;
  int                 speed_items;
  int                 motor_count;

  function new(int motors);
    motor_count = motors;
    foreach (gains[i]) gains[i] = msc_pkg::GAIN_RESET;
    mismatches    = 0;
    bytes_checked = 0;
    speed_items   = 0;
  endfunction

  function void set_gain(logic [7:0] idx, logic [15:0] val);
    if (idx < msc_pkg::GAIN_COUNT) gains[idx] = val;
  endfunction

  // speed * gain / 256, truncated toward zero, clamped to +-100
  function int scale_speed(logic signed [15:0] spd, logic signed [15:0] g);
    longint prod;
    longint q;
    longint clamp;
    clamp = longint'(msc_pkg::SAT_LIMIT);
    prod  = longint'(spd) * longint'(g);
    q     = prod / 256;
    if (q > clamp) q = clamp;
    if (q < -clamp) q = -clamp;
    return int'(q);
  endfunction

  function void push_byte(logic [7:0] ch, logic last);
    frame_byte_t fb;
    fb.ch   = ch;
    fb.last = last;
    owed_bytes.push_back(fb);
  endfunction

  // Accepted speed transaction: queue the whole frame it produces.
  function void note_speeds(logic [63:0] speeds);
    int                 v;
    int                 mag;
    logic signed [15:0] spd;
    speed_items++;
    for (int m = 0; m < motor_count; m++) begin
      v = 0;
      if (m < msc_pkg::GAIN_COUNT) begin
        spd = speeds[m*msc_pkg::SPEED_W +: msc_pkg::SPEED_W];
        v   = scale_speed(spd, gains[m]);
      end
      mag = (v < 0) ? -v : v;
      push_byte(msc_pkg::CH_ONE + 8'(m), 1'b0);
      push_byte((v < 0) ? msc_pkg::CH_REV : msc_pkg::CH_FWD, 1'b0);
      push_byte(msc_pkg::CH_ZERO + 8'((mag / 100) % 10), 1'b0);
      push_byte(msc_pkg::CH_ZERO + 8'((mag / 10) % 10), 1'b0);
      push_byte(msc_pkg::CH_ZERO + 8'(mag % 10), 1'b0);
    end
    push_byte(msc_pkg::CH_CR, 1'b0);
    push_byte(msc_pkg::CH_LF, 1'b1);
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch %0d: %s", mismatches, what);
  endfunction

  // Accepted output transaction: compare with the oldest owed byte.
  function void check_byte(logic [7:0] ch, logic last);
    frame_byte_t exp_b;
    bytes_checked++;
    if (owed_bytes.size() == 0) begin
      report($sformatf("unexpected byte 0x%02h last=%0b", ch, last));
      return;
    end
    exp_b = owed_bytes.pop_front();
    if (ch !== exp_b.ch || last !== exp_b.last)
      report($sformatf("byte %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       bytes_checked, exp_b.ch, exp_b.last, ch, last));
  endfunction

  function int pending();
    return owed_bytes.size();
  endfunction
endclass

module testbench;

  localparam int MOTOR_COUNT    = 4;
  // worst case: ~260 frames x 22 bytes, each byte possibly held by a backpressure burst, plus gaps; x5
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 38;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // speed_motor1..speed_motor4 from bit 0
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // out_byte
  logic        m_axis_tlast;   // last_byte
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  frame_scoreboard sb = new(MOTOR_COUNT);

  // Idle control: percent chance per cycle/item of starting an idle
  // burst; calm switches all idling off for the closing stretch.
  int unsigned stall_pct = 0;
  int unsigned gap_pct   = 0;
  bit          calm      = 1'b0;
  int          stall_left;
  int          gain_writes = 0;

  always #6 clk_i = ~clk_i;

  motor_speed_command_formatter #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Frame sink: random backpressure bursts, fully open once calm.
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output monitor: every accepted byte goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_byte(m_axis_tdata, m_axis_tlast);
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("tb: timeout with %0d bytes outstanding", sb.pending());
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] pack_speeds(logic signed [15:0] s1, logic signed [15:0] s2,
                                               logic signed [15:0] s3, logic signed [15:0] s4);
    return {s4, s3, s2, s1};
  endfunction

  // Mostly modest gains so plenty of values land inside +-100.
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(0, 800) - 400);
    endcase
  endfunction

  // Idle the speed input with junk on the data bus.
  task automatic sender_gap(int n);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= {$urandom, $urandom};
    repeat (n) @(posedge clk_i);
  endtask

  // One speed transaction; tvalid is left high for a back-to-back follower.
  task automatic send_speeds(logic [63:0] speeds);
    if (!calm && $urandom_range(0, 99) < gap_pct) sender_gap($urandom_range(1, 17));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= speeds;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_speeds(speeds);
  endtask

  // Stop sending and hold off until every owed frame byte has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One register write; caller drops cfg_valid_i after the batch.
  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_gain(idx, val);
    gain_writes++;
  endtask

  task automatic set_gains(logic [15:0] g1, logic [15:0] g2, logic [15:0] g3, logic [15:0] g4);
    wait_drained();
    write_reg(msc_pkg::REG_GAIN_MOTOR1, g1);
    write_reg(msc_pkg::REG_GAIN_MOTOR2, g2);
    write_reg(msc_pkg::REG_GAIN_MOTOR3, g3);
    write_reg(msc_pkg::REG_GAIN_MOTOR4, g4);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: reset gains of 1.0, saturation edges, sign, digits
    stall_pct = 10;
    gap_pct   = 20;
    send_speeds(pack_speeds(0, 0, 0, 0));
    send_speeds(pack_speeds(100, -100, 101, -101));
    send_speeds(pack_speeds(32767, -32768, 99, -99));
    send_speeds(pack_speeds(1, -1, -32768, 32767));
    send_speeds(pack_speeds(255, -255, 10, -10));

    // --- directed: half gain (truncation toward zero), negative and extreme
    // gains; also writes to unmapped indexes, which must be dropped
    set_gains(16'sd128, -16'sd256, 16'sh7FFF, 16'sh8000);
    write_reg(8'(msc_pkg::GAIN_COUNT), 16'h0000);
    write_reg(8'hFF, 16'h1234);
    cfg_valid_i <= 1'b0;
    send_speeds(pack_speeds(-1, -1, 0, 0));          // -0.5 rounds to "F000"
    send_speeds(pack_speeds(-3, 100, 1, 1));         // -1.5 -> -1, products clamp
    send_speeds(pack_speeds(3, -32768, -1, -32768)); // largest positive product
    send_speeds(pack_speeds(-32768, 32767, -32768, 32767));
    send_speeds(pack_speeds(201, -201, 0, -1));

    // --- directed: zero gain wipes everything
    set_gains(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_speeds(pack_speeds(32767, -32768, 12345, -12345));
    send_speeds(pack_speeds(-1, 1, 256, -256));

    // --- directed: tiny gains, just under and exactly at the limit
    set_gains(16'sd0, 16'sd1, -16'sd1, msc_pkg::GAIN_RESET);
    send_speeds(pack_speeds(-32768, 25600, -25599, 5));
    send_speeds(pack_speeds(1, 25599, -25600, -5));
    send_speeds(pack_speeds(-1, -25600, 25600, 42));

    // --- random phases: fresh gains each time, varying idle pressure
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
      if ($urandom_range(0, 2) == 0) begin
        write_reg(8'($urandom_range(msc_pkg::GAIN_COUNT, 255)), 16'($urandom));
        cfg_valid_i <= 1'b0;
      end
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 8;
        default: stall_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      // closing stretch runs at full rate on both sides
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_speeds({pick_speed(), pick_speed(), pick_speed(), pick_speed()});
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d bytes never arrived", sb.pending()));

    $display("tb: covered %0d speed frames, %0d bytes, %0d register writes",
             sb.speed_items, sb.bytes_checked, gain_writes);
    $display("tb: gains swept over extremes, zero, +-1 and random; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
